// ===== hw/rtl/pfbr_pkg.sv =====
// Package for the pixel format converter: register codes, mode codes,
// queue entry type and the exact channel scaling functions.
// No dependencies.
`default_nettype none

package pfbr_pkg;

    localparam int MAX_ROW_WIDTH_DEF = 4096;

    localparam int COLOR_W     = 16;
    localparam int ALPHA_W     = 8;
    localparam int DATA_W      = 32;
    localparam int BYTES_W     = 3;
    localparam int MODE_W      = 2;
    localparam int ROW_WIDTH_W = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b1;

    localparam logic [MODE_W-1:0] MODE_565_PASS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_555_TO_565 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_565_RGBA  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_555_RGBA  = 2'd3;

    localparam logic [BYTES_W-1:0] BYTES_2 = 3'd2;
    localparam logic [BYTES_W-1:0] BYTES_4 = 3'd4;

    localparam logic [MODE_W-1:0] MODE_RESET      = MODE_565_PASS;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd1;

    // Reciprocals ceil(2^20 / 31) and ceil(2^20 / 63); the truncation error
    // stays below one step of the divisor over the whole input range.
    localparam logic [15:0] RECIP31 = 16'd33826;
    localparam logic [15:0] RECIP63 = 16'd16645;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [BYTES_W-1:0] nbytes;
        logic               pad;
    } pfbr_entry_t;

    // floor(c * 255 / 31)
    function automatic logic [7:0] scale5to8(input logic [4:0] c);
        logic [12:0] x;
        logic [28:0] p;
        x = {c, 8'b0} - {8'b0, c};
        p = 29'(x) * 29'(RECIP31);
        return p[27:20];
    endfunction

    // floor(c * 255 / 63)
    function automatic logic [7:0] scale6to8(input logic [5:0] c);
        logic [13:0] x;
        logic [28:0] p;
        x = {c, 8'b0} - {8'b0, c};
        p = 29'(x) * 29'(RECIP63);
        return p[27:20];
    endfunction

    // floor(c * 63 / 31)
    function automatic logic [5:0] scale5to6(input logic [4:0] c);
        logic [10:0] x;
        logic [28:0] p;
        x = {c, 6'b0} - {6'b0, c};
        p = 29'(x) * 29'(RECIP31);
        return p[25:20];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfbr_if.sv =====
// Channel interfaces for the pixel format converter: pixel input,
// result output and configuration write.
// Depends on pfbr_pkg.
`default_nettype none

interface pfbr_in_if;
    logic                           valid;
    logic                           ready;
    logic [pfbr_pkg::COLOR_W-1:0]   color;
    logic [pfbr_pkg::ALPHA_W-1:0]   alpha;

    modport source (output valid, output color, output alpha, input ready);
    modport sink (input valid, input color, input alpha, output ready);
endinterface

interface pfbr_out_if;
    logic                           valid;
    logic                           ready;
    logic [pfbr_pkg::DATA_W-1:0]    out_data;
    logic [pfbr_pkg::BYTES_W-1:0]   out_bytes;
    logic                           is_pad;
    logic                           last;

    modport source (output valid, output out_data, output out_bytes, output is_pad,
                    output last, input ready);
    modport sink (input valid, input out_data, input out_bytes, input is_pad,
                  input last, output ready);
endinterface

interface pfbr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pfbr_pkg::CFG_IDX_W-1:0]    index;
    logic [pfbr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pixel_format_to_bmp_rows_core.sv =====
// Pixel format converter, top level: configuration registers, front end,
// queue and back end. Depends on pfbr_pkg, pfbr_if, pfbr_front,
// pfbr_queue and pfbr_back.
//
// The block takes one 16-bit pixel word per clock and returns one result
// word per clock while the output is ready and the queue has room: each
// pixel yields one word, and in the 2-byte modes a row of odd width adds
// one padding word after its last pixel. An accepted pixel is written into
// the two-entry queue, then loaded into the output register; a full queue
// holds the input not ready. The configuration port is always ready and
// should be written only while no pixel is in flight.
`default_nettype none

module pixel_format_to_bmp_rows_core #(
    parameter int MAX_ROW_WIDTH = pfbr_pkg::MAX_ROW_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pfbr_in_if.sink    in_ch,
    pfbr_out_if.source out_ch,
    pfbr_cfg_if.sink   cfg
);

    logic [pfbr_pkg::MODE_W-1:0]      mode_reg;
    logic [pfbr_pkg::ROW_WIDTH_W-1:0] row_width_reg;
    logic                             push_valid;
    logic                             push_ready;
    pfbr_pkg::pfbr_entry_t            push_entry;
    logic                             q_valid;
    logic                             q_pop;
    pfbr_pkg::pfbr_entry_t            q_entry;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pfbr_pkg::MODE_RESET;
            row_width_reg <= pfbr_pkg::ROW_WIDTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pfbr_pkg::CFG_MODE:
                begin
                    mode_reg <= cfg.data[pfbr_pkg::MODE_W-1:0];
                end
                pfbr_pkg::CFG_ROW_WIDTH:
                begin
                    row_width_reg <= cfg.data[pfbr_pkg::ROW_WIDTH_W-1:0];
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    pfbr_front #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .color      (in_ch.color),
        .alpha      (in_ch.alpha),
        .mode       (mode_reg),
        .row_width  (row_width_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    pfbr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    pfbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.out_data),
        .out_bytes (out_ch.out_bytes),
        .is_pad    (out_ch.is_pad),
        .last      (out_ch.last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pfbr_front.sv =====
// Front end: accepts pixels, converts them per mode, tracks the row
// column and flags rows that need a padding word. Depends on pfbr_pkg.
`default_nettype none

module pfbr_front #(
    parameter int MAX_ROW_WIDTH = pfbr_pkg::MAX_ROW_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [pfbr_pkg::COLOR_W-1:0]         color,
    input  wire logic [pfbr_pkg::ALPHA_W-1:0]         alpha,
    input  wire logic [pfbr_pkg::MODE_W-1:0]          mode,
    input  wire logic [pfbr_pkg::ROW_WIDTH_W-1:0]     row_width,
    output logic                                      push_valid,
    input  wire logic                                 push_ready,
    output pfbr_pkg::pfbr_entry_t                     push_entry
);

    localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int EW = (COL_W + 1 > pfbr_pkg::ROW_WIDTH_W) ?
                        COL_W + 1 : pfbr_pkg::ROW_WIDTH_W;
    localparam logic [EW-1:0] MAX_W = EW'(MAX_ROW_WIDTH);

    logic [COL_W-1:0]          column_reg;
    logic [COL_W-1:0]          column_next;
    logic [EW-1:0]             width_raw;
    logic [EW-1:0]             width_eff;
    logic [EW-1:0]             column_inc;
    logic                      row_end;
    logic                      accept;
    logic [pfbr_pkg::DATA_W-1:0]  data;
    logic [pfbr_pkg::BYTES_W-1:0] nbytes;

    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        width_raw = EW'(row_width);
        if (width_raw == '0)
        begin
            width_eff = EW'(1);
        end
        else if (width_raw > MAX_W)
        begin
            width_eff = MAX_W;
        end
        else
        begin
            width_eff = width_raw;
        end
        column_inc = EW'(column_reg) + EW'(1);
        row_end    = (column_inc >= width_eff);
        column_next = row_end ? '0 : column_inc[COL_W-1:0];
    end

    always_comb
    begin
        case (mode)
            pfbr_pkg::MODE_565_PASS:
            begin
                data   = {16'b0, color};
                nbytes = pfbr_pkg::BYTES_2;
            end
            pfbr_pkg::MODE_555_TO_565:
            begin
                data   = {16'b0, color[14:10], pfbr_pkg::scale5to6(color[9:5]), color[4:0]};
                nbytes = pfbr_pkg::BYTES_2;
            end
            pfbr_pkg::MODE_565_RGBA:
            begin
                data   = {alpha, pfbr_pkg::scale5to8(color[4:0]),
                          pfbr_pkg::scale6to8(color[10:5]), pfbr_pkg::scale5to8(color[15:11])};
                nbytes = pfbr_pkg::BYTES_4;
            end
            default:
            begin
                data   = {alpha, pfbr_pkg::scale5to8(color[4:0]),
                          pfbr_pkg::scale5to8(color[9:5]), pfbr_pkg::scale5to8(color[14:10])};
                nbytes = pfbr_pkg::BYTES_4;
            end
        endcase
        push_entry.data   = data;
        push_entry.nbytes = nbytes;
        push_entry.pad    = row_end && (nbytes == pfbr_pkg::BYTES_2) && width_eff[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
        end
        else if (accept)
        begin
            column_reg <= column_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfbr_queue.sv =====
// Two-entry queue between the front and back ends of the pixel format
// converter. Depends on pfbr_pkg.
`default_nettype none

module pfbr_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire pfbr_pkg::pfbr_entry_t push_entry,
    output logic                       pop_valid,
    input  wire logic                  pop,
    output pfbr_pkg::pfbr_entry_t      pop_entry
);

    pfbr_pkg::pfbr_entry_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfbr_back.sv =====
// Back end: takes converted pixels from the queue and drives the output
// register, inserting a padding word after a row end when flagged.
// Depends on pfbr_pkg.
`default_nettype none

module pfbr_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire pfbr_pkg::pfbr_entry_t       q_entry,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pfbr_pkg::DATA_W-1:0]      out_data,
    output logic [pfbr_pkg::BYTES_W-1:0]     out_bytes,
    output logic                             is_pad,
    output logic                             last
);

    logic                          valid_reg;
    logic                          pad_pend_reg;
    logic [pfbr_pkg::DATA_W-1:0]   data_reg;
    logic [pfbr_pkg::BYTES_W-1:0]  bytes_reg;
    logic                          is_pad_reg;
    logic                          last_reg;
    logic                          load;

    assign load      = !valid_reg || out_ready;
    assign q_pop     = load && !pad_pend_reg && q_valid;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_bytes = bytes_reg;
    assign is_pad    = is_pad_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            pad_pend_reg <= 1'b0;
        end
        else if (load)
        begin
            if (pad_pend_reg)
            begin
                valid_reg    <= 1'b1;
                pad_pend_reg <= 1'b0;
            end
            else if (q_valid)
            begin
                valid_reg    <= 1'b1;
                pad_pend_reg <= q_entry.pad;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pad_pend_reg)
            begin
                data_reg   <= '0;
                bytes_reg  <= pfbr_pkg::BYTES_2;
                is_pad_reg <= 1'b1;
                last_reg   <= 1'b1;
            end
            else
            begin
                data_reg   <= q_entry.data;
                bytes_reg  <= q_entry.nbytes;
                is_pad_reg <= 1'b0;
                last_reg   <= !q_entry.pad;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfbr_checker.sv =====
// Port-level checks for the pixel format converter, bound to the top
// level. Depends on pfbr_pkg and pixel_format_to_bmp_rows_core.
`default_nettype none

module pfbr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [pfbr_pkg::DATA_W-1:0]     out_data,
    input wire logic [pfbr_pkg::BYTES_W-1:0]    out_bytes,
    input wire logic                            is_pad,
    input wire logic                            last
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_bytes)
            && $stable(is_pad) && $stable(last))
        else $error("Output word changed while stalled.");

    a_pad_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_pad |-> out_data == '0 && out_bytes == pfbr_pkg::BYTES_2 && last)
        else $error("Padding word is malformed.");

    a_pad_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && is_pad)
        else $error("Padding word did not follow a pixel word marked as not last.");

    a_rgba_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_bytes == pfbr_pkg::BYTES_4 |-> last && !is_pad)
        else $error("Four-byte word must be the only word of its pixel.");

    a_pad_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_pad |=> !(out_valid && is_pad))
        else $error("Two padding words in a row.");

endmodule

bind pixel_format_to_bmp_rows_core pfbr_checker u_pfbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.out_data),
    .out_bytes (out_ch.out_bytes),
    .is_pad    (out_ch.is_pad),
    .last      (out_ch.last)
);

`default_nettype wire

// ===== sim/pixel_format_to_bmp_rows_core_test.sv =====
// Self-checking testbench for pixel_format_to_bmp_rows_core: a directed table, then random
// pixel streams under random input gaps and output stalls, checked word by word.
// Depends on pfbr_pkg, pfbr_if and the core's RTL.

module pixel_format_to_bmp_rows_core_test;
    import pfbr_pkg::*;

    localparam int PIXEL_TOTAL   = 1350;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int DIRECTED_ROWS = 32;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [BYTES_W-1:0] nbytes;
        logic               pad;
        logic               last;
    } word_t;

    localparam word_t PAD_WORD = '{data: '0, nbytes: BYTES_2, pad: 1'b1, last: 1'b1};

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic [COLOR_W-1:0]    color;
        logic [ALPHA_W-1:0]    alpha;
        logic                  typed;
        logic [DATA_W-1:0]     data;
        logic [BYTES_W-1:0]    nbytes;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;

    pfbr_in_if  pix_ch();
    pfbr_out_if word_ch();
    pfbr_cfg_if reg_ch();

    pixel_format_to_bmp_rows_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (pix_ch),
        .out_ch (word_ch),
        .cfg    (reg_ch)
    );

    logic [MODE_W-1:0]      conv_mode      = MODE_RESET;
    logic [ROW_WIDTH_W-1:0] conv_row_width = ROW_WIDTH_RESET;
    logic [11:0]            conv_column    = '0;

    word_t pending_words[$];
    int    mismatches = 0;
    int    hold_requests = 0;
    int    burst_left = 0;
    bit    pixels_since_write = 1'b0;

    step_t directed [DIRECTED_ROWS] = '{
        '{ROW_PIXEL, '0, '0, 16'h0000, 8'h00, 1'b1, 32'h0000_0000, BYTES_2},
        '{ROW_PIXEL, '0, '0, 16'hFFFF, 8'hFF, 1'b1, 32'h0000_FFFF, BYTES_2},
        '{ROW_REG, CFG_MODE, 13'(MODE_555_TO_565), '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'h7FFF, 8'h00, 1'b1, 32'h0000_FFFF, BYTES_2},
        '{ROW_PIXEL, '0, '0, 16'h8000, 8'hFF, 1'b1, 32'h0000_0000, BYTES_2},
        '{ROW_PIXEL, '0, '0, 16'h5A5A, 8'h3C, 1'b0, '0, '0},
        '{ROW_REG, CFG_MODE, 13'(MODE_565_RGBA), '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, BYTES_4},
        '{ROW_PIXEL, '0, '0, 16'h0000, 8'h00, 1'b1, 32'h0000_0000, BYTES_4},
        '{ROW_PIXEL, '0, '0, 16'hF800, 8'h80, 1'b1, 32'h8000_00FF, BYTES_4},
        '{ROW_PIXEL, '0, '0, 16'h07E0, 8'h01, 1'b1, 32'h0100_FF00, BYTES_4},
        '{ROW_REG, CFG_MODE, 13'(MODE_555_RGBA), '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'h7FFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, BYTES_4},
        '{ROW_PIXEL, '0, '0, 16'h8000, 8'h00, 1'b1, 32'h0000_0000, BYTES_4},
        '{ROW_PIXEL, '0, '0, 16'h001F, 8'h7F, 1'b1, 32'h7FFF_0000, BYTES_4},
        '{ROW_REG, CFG_ROW_WIDTH, 13'd0, '0, '0, 1'b0, '0, '0},
        '{ROW_REG, CFG_MODE, 13'(MODE_565_PASS), '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'h1234, 8'h55, 1'b1, 32'h0000_1234, BYTES_2},
        '{ROW_REG, CFG_ROW_WIDTH, 13'd8191, '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'hABCD, 8'hAA, 1'b0, '0, '0},
        '{ROW_REG, CFG_ROW_WIDTH, 13'd4096, '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'h3C3C, 8'h11, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'hC3C3, 8'hEE, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'h0F0F, 8'h99, 1'b0, '0, '0},
        '{ROW_REG, CFG_ROW_WIDTH, 13'd3, '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'hF0F0, 8'h66, 1'b0, '0, '0},
        '{ROW_REG, CFG_MODE, 13'(MODE_565_RGBA), '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'h1111, 8'h22, 1'b0, '0, '0},
        '{ROW_REG, CFG_MODE, 13'(MODE_555_TO_565), '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'h2222, 8'h33, 1'b0, '0, '0},
        '{ROW_REG, CFG_MODE, 13'(MODE_565_PASS), '0, '0, 1'b0, '0, '0},
        '{ROW_PIXEL, '0, '0, 16'h4444, 8'h44, 1'b0, '0, '0}
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] widen_channel(input int level, input int top);
        return 8'((level * 255) / top);
    endfunction

    function automatic word_t convert_pixel(input logic [COLOR_W-1:0] color,
                                            input logic [ALPHA_W-1:0] alpha,
                                            output logic padded);
        word_t result;
        int    width;
        logic  row_end;
        result = '0;
        case (conv_mode)
            MODE_565_PASS:
            begin
                result.data   = {16'h0000, color};
                result.nbytes = BYTES_2;
            end
            MODE_555_TO_565:
            begin
                result.data   = {16'h0000, color[14:10], 6'((int'(color[9:5]) * 63) / 31),
                                 color[4:0]};
                result.nbytes = BYTES_2;
            end
            MODE_565_RGBA:
            begin
                result.data   = {alpha, widen_channel(color[4:0], 31),
                                 widen_channel(color[10:5], 63), widen_channel(color[15:11], 31)};
                result.nbytes = BYTES_4;
            end
            default:
            begin
                result.data   = {alpha, widen_channel(color[4:0], 31),
                                 widen_channel(color[9:5], 31), widen_channel(color[14:10], 31)};
                result.nbytes = BYTES_4;
            end
        endcase
        width = int'(conv_row_width);
        if (width == 0)
            width = 1;
        if (width > MAX_ROW_WIDTH_DEF)
            width = MAX_ROW_WIDTH_DEF;
        row_end     = (int'(conv_column) + 1 >= width);
        padded      = row_end && (result.nbytes == BYTES_2) && (width % 2 == 1);
        conv_column = row_end ? '0 : conv_column + 1'b1;
        result.last = !padded;
        return result;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_row_width();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'(MAX_ROW_WIDTH_DEF);
            2: return CFG_DATA_W'($urandom_range(MAX_ROW_WIDTH_DEF + 1, 8191));
            3: return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(1, 9));
        endcase
    endfunction

    task automatic report(input string what, input logic [DATA_W-1:0] got,
                          input logic [DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        if (pixels_since_write)
            wait_idle();
        pixels_since_write = 1'b0;
        reg_ch.valid <= 1'b1;
        reg_ch.index <= index;
        reg_ch.data  <= value;
        do
            @(posedge clk);
        while (!reg_ch.ready);
        if (index == CFG_MODE)
            conv_mode = value[MODE_W-1:0];
        else
            conv_row_width = value;
    endtask

    task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic [ALPHA_W-1:0] alpha,
                              input logic typed, input logic [DATA_W-1:0] data,
                              input logic [BYTES_W-1:0] nbytes);
        word_t first;
        logic  padded;
        int    gap;
        reg_ch.valid <= 1'b0;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixels_since_write = 1'b1;
        first = convert_pixel(color, alpha, padded);
        if (typed)
        begin
            first.data   = data;
            first.nbytes = nbytes;
        end
        pending_words.push_back(first);
        if (padded)
            pending_words.push_back(PAD_WORD);
        pix_ch.valid <= 1'b1;
        pix_ch.color <= color;
        pix_ch.alpha <= alpha;
        do
            @(posedge clk);
        while (!pix_ch.ready);
    endtask

    // The receiver alternates between always ready, random stalls and a repeating
    // stall pattern, and holds off for a long stretch whenever the sender asks.
    initial
    begin : receiver
        int         seg_left;
        int         style;
        int         hold_left;
        int         holds_done;
        int         step;
        logic [7:0] pattern;
        logic       ready_next;
        seg_left      = 0;
        style         = 0;
        hold_left     = 0;
        holds_done    = 0;
        step          = 0;
        pattern       = '1;
        word_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (seg_left == 0)
            begin
                style    = $urandom_range(0, 2);
                seg_left = $urandom_range(10, 200);
                pattern  = 8'($urandom()) | 8'h01;
            end
            seg_left--;
            step++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (style == 0)
                ready_next = 1'b1;
            else if (style == 1)
                ready_next = ($urandom_range(0, 3) != 0);
            else
                ready_next = pattern[step % 8];
            word_ch.ready <= ready_next;
        end
    end

    always @(posedge clk)
    begin : check_words
        word_t want;
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (pending_words.size() == 0)
                report("word with none expected", word_ch.out_data, '0);
            else
            begin
                want = pending_words.pop_front();
                if (word_ch.out_data !== want.data)
                    report("out_data", word_ch.out_data, want.data);
                if (word_ch.out_bytes !== want.nbytes)
                    report("out_bytes", DATA_W'(word_ch.out_bytes), DATA_W'(want.nbytes));
                if (word_ch.is_pad !== want.pad)
                    report("is_pad", DATA_W'(word_ch.is_pad), DATA_W'(want.pad));
                if (word_ch.last !== want.last)
                    report("last", DATA_W'(word_ch.last), DATA_W'(want.last));
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        int phase;
        int phase_len;
        pix_ch.valid = 1'b0;
        pix_ch.color = '0;
        pix_ch.alpha = '0;
        reg_ch.valid = 1'b0;
        reg_ch.index = '0;
        reg_ch.data  = '0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_REG)
                write_reg(directed[i].index, directed[i].value);
            else
                send_pixel(directed[i].color, directed[i].alpha, directed[i].typed,
                           directed[i].data, directed[i].nbytes);
        end

        sent  = 0;
        phase = 0;
        while (sent < PIXEL_TOTAL)
        begin
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_MODE, CFG_DATA_W'($urandom()));
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_ROW_WIDTH, pick_row_width());
            phase_len = $urandom_range(8, 60);
            if (phase % 10 == 3)
            begin
                hold_requests++;
                phase_len = 150;
            end
            repeat (phase_len)
                send_pixel(COLOR_W'($urandom()), ALPHA_W'($urandom()), 1'b0, '0, '0);
            sent += phase_len;
            phase++;
        end

        wait_idle();
        if (mismatches == 0 && pending_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
